>>> rtl/hsw_pkg.sv
package hsw_pkg;

    // sequencer steps, one per clock; IDLE waits for input and OUT waits for a free output register
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CLAMP,
        ST_DIFF,
        ST_SMUL,
        ST_ACC,
        ST_DLY,
        ST_ADDR,
        ST_RDL,
        ST_RDR,
        ST_TAPL,
        ST_TAPR,
        ST_WETL,
        ST_WETR,
        ST_OUT
    } hsw_state_t;

    typedef struct packed {
        hsw_state_t st;
        logic       accept;
        logic       out_load;
    } hsw_ctl_t;

    localparam int REG_IDX_W = 3;
    localparam int CFG_W     = 19;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_DELAY_SPAN   = 3'd0;
    localparam reg_idx_t REG_SMOOTH_COEF  = 3'd1;
    localparam reg_idx_t REG_PAN_OFFSET   = 3'd2;
    localparam reg_idx_t REG_PAN_CV_DEPTH = 3'd3;
    localparam reg_idx_t REG_MIX_OFFSET   = 3'd4;
    localparam reg_idx_t REG_MIX_CV_DEPTH = 3'd5;

    localparam logic [18:0] DELAY_SPAN_RST  = 19'd24576;
    localparam logic [15:0] SMOOTH_COEF_RST = 16'd429;

    // unity in Q1.14
    localparam logic signed [15:0] CTL_ONE = 16'sd16384;

endpackage

>>> rtl/hsw_store.sv
module hsw_store #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

>>> rtl/hsw_seq.sv
module hsw_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             out_busy,
    output hsw_pkg::hsw_ctl_t ctl
);

    hsw_pkg::hsw_state_t state_reg;
    hsw_pkg::hsw_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hsw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ctl.st       = state_reg;
        ctl.accept   = 1'b0;
        ctl.out_load = 1'b0;
        case (state_reg)
            hsw_pkg::ST_IDLE:
            begin
                ctl.accept = in_valid;
                if (in_valid)
                begin
                    state_next = hsw_pkg::ST_MUL;
                end
            end
            hsw_pkg::ST_MUL:   state_next = hsw_pkg::ST_CLAMP;
            hsw_pkg::ST_CLAMP: state_next = hsw_pkg::ST_DIFF;
            hsw_pkg::ST_DIFF:  state_next = hsw_pkg::ST_SMUL;
            hsw_pkg::ST_SMUL:  state_next = hsw_pkg::ST_ACC;
            hsw_pkg::ST_ACC:   state_next = hsw_pkg::ST_DLY;
            hsw_pkg::ST_DLY:   state_next = hsw_pkg::ST_ADDR;
            hsw_pkg::ST_ADDR:  state_next = hsw_pkg::ST_RDL;
            hsw_pkg::ST_RDL:   state_next = hsw_pkg::ST_RDR;
            hsw_pkg::ST_RDR:   state_next = hsw_pkg::ST_TAPL;
            hsw_pkg::ST_TAPL:  state_next = hsw_pkg::ST_TAPR;
            hsw_pkg::ST_TAPR:  state_next = hsw_pkg::ST_WETL;
            hsw_pkg::ST_WETL:  state_next = hsw_pkg::ST_WETR;
            hsw_pkg::ST_WETR:  state_next = hsw_pkg::ST_OUT;
            hsw_pkg::ST_OUT:
            begin
                // park here until the output register is free
                if (!out_busy)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = hsw_pkg::ST_IDLE;
                end
            end
            default:           state_next = hsw_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> rtl/haas_stereo_widener_unit.sv
// Channel   Dir  Beat contents (lowest bit up)
// s_axis    in   audio_in[SAMPLE_BITS], pan_cv[16], mix_cv[16], zero pad to bytes
// m_axis    out  left_out[SAMPLE_BITS], right_out[SAMPLE_BITS], zero pad to bytes
// cfg       in   cfg_we, cfg_addr (register index), cfg_wdata (19 bits), no read-back
//
// Flow: a 15-step sequencer walks each sample through the shared multipliers and the
// two read ports of the delay store; a new sample is taken only in the idle step.
// Reset: control state and registers take their reset values at once. The delay
// store is not swept; a fill count makes never-written entries read as zero.
// Stalls: the result waits in the output register while the next sample is taken
// and worked on; the sequencer holds in its last step until that register frees.
module haas_stereo_widener_unit #(
    parameter int STORE_DEPTH = 2048,
    parameter int SAMPLE_BITS = 16,
    localparam int IN_W  = ((SAMPLE_BITS + 32 + 7) / 8) * 8,
    localparam int OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [IN_W-1:0]             s_tdata,   // audio_in, pan_cv, mix_cv
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [OUT_W-1:0]            m_tdata,   // left_out, right_out
    input  logic                        cfg_we,
    input  hsw_pkg::reg_idx_t           cfg_addr,
    input  logic [hsw_pkg::CFG_W-1:0]   cfg_wdata
);

    localparam int AW         = $clog2(STORE_DEPTH);
    localparam int DINT_W     = hsw_pkg::CFG_W - 8;          // whole-sample part of a delay
    localparam int RW         = ((AW > DINT_W) ? AW : DINT_W) + 2;
    localparam int WRAP_STEPS = ((2 ** DINT_W) + STORE_DEPTH - 1) / STORE_DEPTH;
    localparam int TW         = SAMPLE_BITS + 10;            // interpolated tap, x256
    localparam int DP_W       = SAMPLE_BITS + 17;            // dry gain times sample
    localparam int WP_W       = TW + 17;                     // wet gain times tap
    localparam int SUM_W      = SAMPLE_BITS + 28;
    localparam int SH_W       = SUM_W - 23;
    localparam int ROUND_HALF = 1 << 22;

    // ---------------------------------------------------------------- helpers
    function automatic logic signed [15:0] clamp_ctl(input logic signed [15:0] off,
                                                     input logic signed [31:0] prod);
        logic signed [17:0] v;
        v = 18'(off) + 18'(prod >>> 15);
        if (v > 18'sd16384)
        begin
            return hsw_pkg::CTL_ONE;
        end
        else if (v < -18'sd16384)
        begin
            return -hsw_pkg::CTL_ONE;
        end
        return v[15:0];
    endfunction

    // bring a possibly negative position back into the store
    function automatic logic [AW-1:0] wrap_idx(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] t;
        t = v;
        for (int k = 0; k < WRAP_STEPS; k++)
        begin
            if (t < 0)
            begin
                t = t + RW'(STORE_DEPTH);
            end
        end
        return t[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
        return (i == AW'(STORE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    // linear interpolation a*256 + (b-a)*f
    function automatic logic signed [TW-1:0] tap_calc(input logic signed [SAMPLE_BITS-1:0] a,
                                                      input logic signed [SAMPLE_BITS-1:0] b,
                                                      input logic [7:0] f);
        logic signed [SAMPLE_BITS:0] d;
        d = (SAMPLE_BITS + 1)'(b) - (SAMPLE_BITS + 1)'(a);
        return (TW'(a) <<< 8) + TW'(d) * $signed({1'b0, f});
    endfunction

    // round, scale down by 2^23 and saturate
    function automatic logic [SAMPLE_BITS-1:0] out_calc(input logic signed [DP_W-1:0] dp,
                                                        input logic signed [WP_W-1:0] w);
        logic signed [SUM_W-1:0] s;
        logic signed [SH_W-1:0]  v;
        s = (SUM_W'(dp) <<< 8) + SUM_W'(w) + SUM_W'(ROUND_HALF);
        v = SH_W'(s >>> 23);
        if (v[SH_W-1:SAMPLE_BITS-1] == '0 || v[SH_W-1:SAMPLE_BITS-1] == '1)
        begin
            return v[SAMPLE_BITS-1:0];
        end
        return {v[SH_W-1], {(SAMPLE_BITS - 1){~v[SH_W-1]}}};
    endfunction

    // ---------------------------------------------------------------- sequencer
    hsw_pkg::hsw_ctl_t ctl;

    hsw_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .out_busy (m_tvalid && !m_tready),
        .ctl      (ctl)
    );

    assign s_tready = (ctl.st == hsw_pkg::ST_IDLE);

    // ---------------------------------------------------------------- control state
    logic [18:0]        span_reg;
    logic [15:0]        coef_reg;
    logic signed [15:0] pan_off_reg;
    logic signed [15:0] pan_dep_reg;
    logic signed [15:0] mix_off_reg;
    logic signed [15:0] mix_dep_reg;

    logic [AW-1:0]      wp_reg;
    logic [AW-1:0]      wp_next;
    logic [AW:0]        fill_reg;       // entries written since reset, saturating
    logic [AW:0]        fill_next;
    logic signed [31:0] ps_reg;         // smoothed pan, Q1.30
    logic signed [31:0] ps_next;
    logic               m_tvalid_reg;
    logic               m_tvalid_next;

    // ---------------------------------------------------------------- payload
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [15:0]            pan_cv_reg;
    logic signed [15:0]            mix_cv_reg;
    logic signed [31:0]            pan_prod_reg;
    logic signed [31:0]            mix_prod_reg;
    logic signed [15:0]            pan_reg;
    logic signed [15:0]            mix_reg;
    logic signed [32:0]            diff_reg;
    logic signed [49:0]            smul_reg;
    logic signed [DP_W-1:0]        dry_prod_reg;
    logic [18:0]                   delay_reg;
    logic                          left_dly_reg;
    logic                          right_dly_reg;
    logic [AW-1:0]                 idx_l_reg;
    logic [AW-1:0]                 idx_r_reg;
    logic [7:0]                    frac_l_reg;
    logic [7:0]                    frac_r_reg;
    logic                          ok_a_reg;
    logic                          ok_b_reg;
    logic signed [SAMPLE_BITS-1:0] a_l_reg;
    logic signed [SAMPLE_BITS-1:0] b_l_reg;
    logic signed [SAMPLE_BITS-1:0] a_r_reg;
    logic signed [SAMPLE_BITS-1:0] b_r_reg;
    logic signed [TW-1:0]          tap_l_reg;
    logic signed [TW-1:0]          tap_r_reg;
    logic signed [WP_W-1:0]        wl_reg;
    logic signed [WP_W-1:0]        wr_reg;
    logic [SAMPLE_BITS-1:0]        left_reg;
    logic [SAMPLE_BITS-1:0]        right_reg;

    // ---------------------------------------------------------------- combinational
    logic signed [16:0]            dry_s;
    logic signed [16:0]            wet_s;
    logic signed [15:0]            p_s;
    logic [14:0]                   p_mag;
    logic [33:0]                   dly_prod;
    logic [DINT_W-1:0]             dint;
    logic [7:0]                    dfr;
    logic signed [RW-1:0]          raw_pos;
    logic [AW-1:0]                 dly_idx;
    logic [7:0]                    dly_frac;
    logic [AW-1:0]                 raddr_a;
    logic [AW-1:0]                 raddr_b;
    logic [SAMPLE_BITS-1:0]        rdata_a;
    logic [SAMPLE_BITS-1:0]        rdata_b;

    always_comb
    begin
        // wet = mix + 1, dry = 1 - mix, both Q0.15 in 0..32768
        wet_s   = 17'(mix_reg) + 17'(hsw_pkg::CTL_ONE);
        dry_s   = 17'(hsw_pkg::CTL_ONE) - 17'(mix_reg);

        // coarse pan, Q1.14; its magnitude sets the delay of one side
        p_s      = ps_reg[31:16];
        p_mag    = p_s[15] ? 15'(-p_s) : p_s[14:0];
        dly_prod = span_reg * p_mag;

        // position = wp*256 - delay, split into whole samples and fraction
        dint     = delay_reg[18:8];
        dfr      = delay_reg[7:0];
        raw_pos  = RW'(wp_reg) - RW'(dint) - RW'(dfr != 8'd0);
        dly_idx  = wrap_idx(raw_pos);
        dly_frac = (dfr == 8'd0) ? 8'd0 : 8'(9'd256 - 9'(dfr));

        // left pair addressed in ST_RDL, right pair in ST_RDR straight after it
        if (ctl.st == hsw_pkg::ST_RDL)
        begin
            raddr_a = idx_l_reg;
            raddr_b = next_idx(idx_l_reg);
        end
        else
        begin
            raddr_a = idx_r_reg;
            raddr_b = next_idx(idx_r_reg);
        end

        ps_next = ps_reg;
        if (ctl.st == hsw_pkg::ST_ACC)
        begin
            ps_next = ps_reg + $signed(smul_reg[47:16]);
        end

        fill_next = fill_reg;
        if (ctl.st == hsw_pkg::ST_MUL && fill_reg != (AW + 1)'(STORE_DEPTH))
        begin
            fill_next = fill_reg + 1'b1;
        end

        wp_next = ctl.out_load ? next_idx(wp_reg) : wp_reg;

        if (ctl.out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // ---------------------------------------------------------------- delay store
    hsw_store #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (SAMPLE_BITS)
    ) u_store (
        .clk     (clk),
        .we      (ctl.st == hsw_pkg::ST_MUL),
        .waddr   (wp_reg),
        .wdata   (x_reg),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg     <= hsw_pkg::DELAY_SPAN_RST;
            coef_reg     <= hsw_pkg::SMOOTH_COEF_RST;
            pan_off_reg  <= '0;
            pan_dep_reg  <= '0;
            mix_off_reg  <= '0;
            mix_dep_reg  <= '0;
            wp_reg       <= '0;
            fill_reg     <= '0;
            ps_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    hsw_pkg::REG_DELAY_SPAN:   span_reg    <= cfg_wdata;
                    hsw_pkg::REG_SMOOTH_COEF:  coef_reg    <= cfg_wdata[15:0];
                    hsw_pkg::REG_PAN_OFFSET:   pan_off_reg <= cfg_wdata[15:0];
                    hsw_pkg::REG_PAN_CV_DEPTH: pan_dep_reg <= cfg_wdata[15:0];
                    hsw_pkg::REG_MIX_OFFSET:   mix_off_reg <= cfg_wdata[15:0];
                    hsw_pkg::REG_MIX_CV_DEPTH: mix_dep_reg <= cfg_wdata[15:0];
                    default:                   ;
                endcase
            end
            wp_reg       <= wp_next;
            fill_reg     <= fill_next;
            ps_reg       <= ps_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        // read-data masks are registered from the addresses, like the store data
        ok_a_reg <= ({1'b0, raddr_a} < fill_reg);
        ok_b_reg <= ({1'b0, raddr_b} < fill_reg);

        case (ctl.st)
            hsw_pkg::ST_IDLE:
            begin
                if (ctl.accept)
                begin
                    x_reg      <= s_tdata[SAMPLE_BITS-1:0];
                    pan_cv_reg <= s_tdata[SAMPLE_BITS+15:SAMPLE_BITS];
                    mix_cv_reg <= s_tdata[SAMPLE_BITS+31:SAMPLE_BITS+16];
                end
            end
            hsw_pkg::ST_MUL:
            begin
                pan_prod_reg <= pan_cv_reg * pan_dep_reg;
                mix_prod_reg <= mix_cv_reg * mix_dep_reg;
            end
            hsw_pkg::ST_CLAMP:
            begin
                pan_reg <= clamp_ctl(pan_off_reg, pan_prod_reg);
                mix_reg <= clamp_ctl(mix_off_reg, mix_prod_reg);
            end
            hsw_pkg::ST_DIFF:
            begin
                diff_reg     <= $signed({pan_reg[15], pan_reg, 16'h0000}) - 33'(ps_reg);
                dry_prod_reg <= dry_s * x_reg;
            end
            hsw_pkg::ST_SMUL:
            begin
                smul_reg <= diff_reg * $signed({1'b0, coef_reg});
            end
            hsw_pkg::ST_DLY:
            begin
                delay_reg     <= dly_prod[32:14];
                left_dly_reg  <= !p_s[15] && (p_s != 16'sd0);
                right_dly_reg <= p_s[15];
            end
            hsw_pkg::ST_ADDR:
            begin
                idx_l_reg  <= left_dly_reg ? dly_idx : wp_reg;
                frac_l_reg <= left_dly_reg ? dly_frac : 8'd0;
                idx_r_reg  <= right_dly_reg ? dly_idx : wp_reg;
                frac_r_reg <= right_dly_reg ? dly_frac : 8'd0;
            end
            hsw_pkg::ST_RDR:
            begin
                a_l_reg <= ok_a_reg ? rdata_a : '0;
                b_l_reg <= ok_b_reg ? rdata_b : '0;
            end
            hsw_pkg::ST_TAPL:
            begin
                a_r_reg   <= ok_a_reg ? rdata_a : '0;
                b_r_reg   <= ok_b_reg ? rdata_b : '0;
                tap_l_reg <= tap_calc(a_l_reg, b_l_reg, frac_l_reg);
            end
            hsw_pkg::ST_TAPR:
            begin
                tap_r_reg <= tap_calc(a_r_reg, b_r_reg, frac_r_reg);
            end
            hsw_pkg::ST_WETL:
            begin
                wl_reg <= wet_s * tap_l_reg;
            end
            hsw_pkg::ST_WETR:
            begin
                wr_reg <= wet_s * tap_r_reg;
            end
            hsw_pkg::ST_OUT:
            begin
                if (ctl.out_load)
                begin
                    left_reg  <= out_calc(dry_prod_reg, wl_reg);
                    right_reg <= out_calc(dry_prod_reg, wr_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'({right_reg, left_reg});

endmodule

>>> rtl/hsw_checker.sv
module hsw_checker #(
    parameter int SAMPLE_BITS = 16,
    localparam int OUT_W = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    logic       in_beat;
    logic       out_beat;
    logic [1:0] pend_reg;
    logic [1:0] pend_next;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    always_comb
    begin
        pend_next = pend_reg + 2'(in_beat) - 2'(out_beat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // one sample in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !s_tready)
        else $error("input taken again right after a beat");

    // no result without a sample behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat |-> (pend_reg != 2'd0))
        else $error("result beat with no sample outstanding");

    // at most one result waiting plus one in work
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 2'd2)
        else $error("too many samples outstanding");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

endmodule

bind haas_stereo_widener_unit hsw_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_hsw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
